// ===== rtl/ztt_pkg.sv =====
package ztt_pkg;

  localparam int unsigned IndexBits   = 12;
  localparam int unsigned PayloadBits = 32;
  localparam int unsigned AgeBits     = 8;
  localparam int unsigned SlotCount   = 1 << IndexBits;
  localparam int unsigned KeyCount    = 128;
  localparam int unsigned KeyBits     = 32;
  localparam int unsigned GroupCount  = 16;
  localparam int unsigned OldAge      = 2;

  localparam logic [2:0] OpLoadKey = 3'd0;
  localparam logic [2:0] OpLookup  = 3'd1;
  localparam logic [2:0] OpInsert  = 3'd2;
  localparam logic [2:0] OpAge     = 3'd3;
  localparam logic [2:0] OpClear   = 3'd4;

  typedef struct packed {
    logic [2:0]  op;
    logic [63:0] first_side_bits;
    logic [63:0] second_side_bits;
    logic [5:0]  search_depth;
    logic [7:0]  entry_age_in;
    logic [31:0] payload_in;
    logic [6:0]  key_slot;
    logic [31:0] key_word;
  } req_t;

  typedef struct packed {
    logic        hit;
    logic [5:0]  found_depth;
    logic [31:0] found_payload;
    logic        replaced;
    logic [11:0] slot_index;
  } rsp_t;

  // Stored entry: masks, depth, age, payload.
  typedef struct packed {
    logic [127:0]           masks;
    logic [5:0]             depth;
    logic [AgeBits-1:0]     age;
    logic [PayloadBits-1:0] payload;
  } entry_t;

endpackage

// ===== rtl/ztt_if.sv =====
interface ztt_req_if;
  logic            valid;
  logic            ready;
  ztt_pkg::req_t   data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ztt_rsp_if;
  logic            valid;
  logic            ready;
  ztt_pkg::rsp_t   data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/zobrist_transposition_table.sv =====
// Accept to result beat: lookup and insert walk all 128 keys, reading one key per cycle,
// then read the entry in StRead and StWait and decide in StDecide; load key writes its key
// in StHash; an unassigned op goes straight to the result; age and clear take a read state
// and a write state per slot. One item at a time: the next beat can be accepted in the cycle
// after the result beat is taken.
// Reset clears control state only; a sweep clears all 4096 used bits, no beat accepted.
module zobrist_transposition_table (
  input logic clk_i,
  input logic rst_ni,
  ztt_req_if.sink   req,
  ztt_rsp_if.source rsp
);

  localparam int unsigned IB = ztt_pkg::IndexBits;
  localparam int unsigned KeyBitsW = ztt_pkg::KeyBits;

  typedef enum logic [3:0] {
    StInit, StIdle, StHash, StHashWait, StRead, StWait, StDecide, StSweepRd, StSweepWr,
    StOut
  } state_e;

  state_e state_q;
  ztt_pkg::req_t req_q;
  ztt_pkg::rsp_t rsp_q;
  logic [7:0] kidx_q;      // walks 0..128 over keys 0..127 (bit 7 marks last)
  logic [KeyBitsW-1:0] hash_q;
  logic [IB-1:0] sidx_q;
  logic kvalid_q;
  logic kbit_q;

  // Memories
  logic [ztt_pkg::KeyBits-1:0] key_mem [ztt_pkg::KeyCount];
  ztt_pkg::entry_t entry_mem [ztt_pkg::SlotCount];
  logic used_mem [ztt_pkg::SlotCount];
  logic [ztt_pkg::KeyBits-1:0] key_rd_q;
  ztt_pkg::entry_t ent_rd_q;
  logic used_rd_q;

  logic key_we, ent_we, used_we, used_wd;
  logic [6:0] key_ra;
  logic [IB-1:0] ent_a;
  ztt_pkg::entry_t ent_wd;

  // Key memory: write on load key, one read a cycle during hashing
  always_ff @(posedge clk_i) begin
    if (key_we) key_mem[req_q.key_slot] <= req_q.key_word;
    key_rd_q <= key_mem[key_ra];
  end

  // Entry and used memories share one address
  always_ff @(posedge clk_i) begin
    if (ent_we) entry_mem[ent_a] <= ent_wd;
    ent_rd_q <= entry_mem[ent_a];
  end
  always_ff @(posedge clk_i) begin
    if (used_we) used_mem[ent_a] <= used_wd;
    used_rd_q <= used_mem[ent_a];
  end

  // Key slot k = square*2+side; mask bit of that key
  logic [6:0] ksq;
  logic [127:0] both;
  assign ksq  = kidx_q[6:0];
  assign both = {req_q.second_side_bits, req_q.first_side_bits};
  assign key_ra = ksq;

  logic hit_c, repl_c;
  logic [ztt_pkg::AgeBits-1:0] agein;
  assign agein = ztt_pkg::AgeBits'(req_q.entry_age_in);
  assign hit_c = used_rd_q && (ent_rd_q.masks == both);
  assign repl_c = !used_rd_q || (req_q.search_depth > ent_rd_q.depth) ||
                  (ent_rd_q.age >= ztt_pkg::AgeBits'(ztt_pkg::OldAge));

  // Memory control
  always_comb begin
    key_we  = 1'b0;
    ent_we  = 1'b0;
    used_we = 1'b0;
    used_wd = 1'b0;
    ent_a   = hash_q[IB-1:0];
    ent_wd  = ent_rd_q;
    unique case (state_q)
      StInit: begin
        used_we = 1'b1;
        ent_a   = sidx_q;
      end
      StIdle: if (req.valid && req.data.op == ztt_pkg::OpClear) begin
        ent_a = '0;
      end
      StSweepRd: ent_a = sidx_q;
      StSweepWr: begin
        ent_a = sidx_q;
        if (req_q.op == ztt_pkg::OpClear) begin
          used_we = 1'b1;
        end else if (used_rd_q && ent_rd_q.age != '1) begin
          ent_we     = 1'b1;
          ent_wd.age = ent_rd_q.age + 1'b1;
        end
      end
      StDecide: begin
        if (req_q.op == ztt_pkg::OpLookup) begin
          if (hit_c) begin
            ent_we     = 1'b1;
            ent_wd.age = '0;
          end
        end else if (repl_c) begin
          ent_we  = 1'b1;
          used_we = 1'b1;
          used_wd = 1'b1;
          ent_wd  = '{masks: both, depth: req_q.search_depth, age: agein,
                      payload: ztt_pkg::PayloadBits'(req_q.payload_in)};
        end
      end
      StHash: key_we = (req_q.op == ztt_pkg::OpLoadKey);
      default: ;
    endcase
  end

  assign req.ready  = (state_q == StIdle);
  assign rsp.valid  = (state_q == StOut);
  assign rsp.data   = rsp_q;

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StInit;
      req_q    <= '0;
      sidx_q   <= '0;
      kidx_q   <= '0;
      kvalid_q <= 1'b0;
      kbit_q   <= 1'b0;
      hash_q   <= '0;
      rsp_q    <= '0;
    end else begin
      unique case (state_q)
        StInit: begin
          sidx_q <= sidx_q + 1'b1;
          if (sidx_q == '1) state_q <= StIdle;
        end
        StIdle: if (req.valid) begin
          req_q  <= req.data;
          rsp_q  <= '0;
          hash_q <= '0;
          kidx_q <= '0;
          kvalid_q <= 1'b0;
          sidx_q <= '0;
          if (req.data.op == ztt_pkg::OpLookup || req.data.op == ztt_pkg::OpInsert ||
              req.data.op == ztt_pkg::OpLoadKey)
            state_q <= StHash;
          else if (req.data.op == ztt_pkg::OpAge || req.data.op == ztt_pkg::OpClear)
            state_q <= StSweepRd;
          else
            state_q <= StOut;
        end
        StHash: begin
          // Read key k this cycle, fold key k-1 read last cycle
          if (req_q.op == ztt_pkg::OpLoadKey) begin
            state_q <= StOut;
          end else begin
            if (kvalid_q && kbit_q) hash_q <= hash_q ^ key_rd_q;
            kbit_q   <= both[{ksq[0], ksq[6:1]}];
            kvalid_q <= !kidx_q[7];
            kidx_q   <= kidx_q + 1'b1;
            if (kidx_q[7]) state_q <= StRead;
          end
        end
        StRead: state_q <= StWait;
        StWait: state_q <= StDecide;
        StDecide: begin
          rsp_q.slot_index <= 12'(hash_q[IB-1:0]);
          if (req_q.op == ztt_pkg::OpLookup) begin
            rsp_q.hit <= hit_c;
            if (hit_c) begin
              rsp_q.found_depth   <= ent_rd_q.depth;
              rsp_q.found_payload <= 32'(ent_rd_q.payload);
            end
          end else begin
            rsp_q.replaced <= repl_c;
          end
          state_q <= StOut;
        end
        StSweepRd: state_q <= StSweepWr;
        StSweepWr: begin
          sidx_q <= sidx_q + 1'b1;
          state_q <= (sidx_q == '1) ? StOut : StSweepRd;
        end
        StOut: if (rsp.ready) state_q <= StIdle;
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule

// ===== verif/zobrist_transposition_table_tb.sv =====
module zobrist_transposition_table_tb;

  // Op codes 5 to 7 are not assigned; the block must answer them with zeros.
  localparam logic [2:0] OpSpareLo = 3'd5;
  localparam logic [2:0] OpSpareHi = 3'd7;
  localparam int unsigned PoolSize = 16;
  localparam int unsigned PhaseItems = 137;
  localparam int unsigned QuietItems = 60;
  localparam int unsigned CycleLimit = 3000000;
  localparam int unsigned DrainCycles = 4200;

  logic clk_i;
  logic rst_ni;

  ztt_req_if req ();
  ztt_rsp_if rsp ();

  zobrist_transposition_table dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req    (req.sink),
    .rsp    (rsp.source)
  );

  // Clock, period 8
  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // Shadow copy of the table
  logic [ztt_pkg::KeyBits-1:0]     zkeys      [ztt_pkg::KeyCount];
  logic [127:0]                    slot_masks [ztt_pkg::SlotCount];
  logic [5:0]                      slot_depth [ztt_pkg::SlotCount];
  logic [ztt_pkg::AgeBits-1:0]     slot_age   [ztt_pkg::SlotCount];
  logic [ztt_pkg::PayloadBits-1:0] slot_pay   [ztt_pkg::SlotCount];
  logic                            slot_used  [ztt_pkg::SlotCount];

  ztt_pkg::rsp_t pending_rsp[$];
  int unsigned mismatches;
  int unsigned cycles;
  bit quiet;

  // Position pool, reused so that lookups and inserts meet stored entries
  logic [63:0] pool_a [PoolSize];
  logic [63:0] pool_b [PoolSize];

  typedef struct {
    ztt_pkg::req_t req;
    bit            typed;
    ztt_pkg::rsp_t exp;
  } dir_row_t;

  function automatic logic [11:0] zobrist_slot(logic [63:0] a, logic [63:0] b);
    logic [31:0] h;
    h = '0;
    for (int sq = 0; sq < 64; sq++) begin
      if (a[sq]) h ^= zkeys[sq * 2];
      if (b[sq]) h ^= zkeys[sq * 2 + 1];
    end
    return h[ztt_pkg::IndexBits-1:0];
  endfunction

  // Applies one beat to the shadow table and returns the answer it must give
  function automatic ztt_pkg::rsp_t apply_table_op(ztt_pkg::req_t r);
    ztt_pkg::rsp_t o;
    logic [11:0] s;
    o = '0;
    case (r.op)
      ztt_pkg::OpLoadKey: zkeys[r.key_slot] = r.key_word;
      ztt_pkg::OpLookup: begin
        s = zobrist_slot(r.first_side_bits, r.second_side_bits);
        o.slot_index = s;
        if (slot_used[s] && slot_masks[s] == {r.second_side_bits, r.first_side_bits}) begin
          slot_age[s] = '0;
          o.hit = 1'b1;
          o.found_depth = slot_depth[s];
          o.found_payload = slot_pay[s];
        end
      end
      ztt_pkg::OpInsert: begin
        s = zobrist_slot(r.first_side_bits, r.second_side_bits);
        o.slot_index = s;
        if (!slot_used[s] || r.search_depth > slot_depth[s] ||
            slot_age[s] >= ztt_pkg::OldAge) begin
          slot_masks[s] = {r.second_side_bits, r.first_side_bits};
          slot_depth[s] = r.search_depth;
          slot_age[s] = r.entry_age_in[ztt_pkg::AgeBits-1:0];
          slot_pay[s] = r.payload_in[ztt_pkg::PayloadBits-1:0];
          slot_used[s] = 1'b1;
          o.replaced = 1'b1;
        end
      end
      ztt_pkg::OpAge: begin
        for (int i = 0; i < ztt_pkg::SlotCount; i++)
          if (slot_used[i] && slot_age[i] != '1) slot_age[i] = slot_age[i] + 1'b1;
      end
      ztt_pkg::OpClear: begin
        for (int i = 0; i < ztt_pkg::SlotCount; i++) slot_used[i] = 1'b0;
      end
      default: ;
    endcase
    return o;
  endfunction

  // Drive one beat, wait for acceptance, then maybe leave a gap
  task automatic send_beat(ztt_pkg::req_t r, bit typed = 1'b0, ztt_pkg::rsp_t exp = '0);
    ztt_pkg::rsp_t p;
    int unsigned gap;
    req.valid <= 1'b1;
    req.data <= r;
    do @(posedge clk_i); while (!req.ready);
    p = apply_table_op(r);
    pending_rsp.push_back(typed ? exp : p);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic park_sender();
    req.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand_mask();
    logic [63:0] m;
    m = {$urandom, $urandom};
    case ($urandom_range(0, 3))
      0: m = m & {$urandom, $urandom};
      1: m = m | {$urandom, $urandom};
      default: ;
    endcase
    return m;
  endfunction

  function automatic ztt_pkg::req_t rand_beat(bit small_keys);
    ztt_pkg::req_t r;
    int unsigned pick;
    int unsigned k;
    r.op = ztt_pkg::OpLookup;
    r.first_side_bits = rand_mask();
    r.second_side_bits = rand_mask();
    r.search_depth = 6'($urandom);
    r.entry_age_in = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
    r.payload_in = $urandom;
    r.key_slot = 7'($urandom);
    r.key_word = small_keys ? ($urandom & 32'hf) : $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 3) r.op = ztt_pkg::OpLoadKey;
    else if (pick < 45) r.op = ztt_pkg::OpLookup;
    else if (pick < 93) r.op = ztt_pkg::OpInsert;
    else if (pick < 96) r.op = ztt_pkg::OpAge;
    else if (pick < 97) r.op = ztt_pkg::OpClear;
    else r.op = 3'($urandom_range(OpSpareLo, OpSpareHi));
    // Mostly positions from the pool, some fresh ones, which replace a pool entry when inserted
    k = $urandom_range(0, PoolSize - 1);
    if ($urandom_range(0, 4) != 0) begin
      r.first_side_bits = pool_a[k];
      r.second_side_bits = pool_b[k];
    end else if (r.op == ztt_pkg::OpInsert) begin
      pool_a[k] = r.first_side_bits;
      pool_b[k] = r.second_side_bits;
    end
    return r;
  endfunction

  // Result side: random stall bursts, no new burst once quiet
  int unsigned stall_left;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp.ready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      rsp.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      rsp.ready <= 1'b0;
      stall_left <= $urandom_range(0, 4);
    end else begin
      rsp.ready <= 1'b1;
    end
  end

  // Compare each result beat with the oldest expectation
  always @(posedge clk_i) begin
    ztt_pkg::rsp_t e;
    if (rst_ni && rsp.valid && rsp.ready) begin
      if (pending_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %p", rsp.data);
      end else begin
        e = pending_rsp.pop_front();
        if (rsp.data.hit !== e.hit || rsp.data.found_depth !== e.found_depth ||
            rsp.data.found_payload !== e.found_payload ||
            rsp.data.replaced !== e.replaced || rsp.data.slot_index !== e.slot_index) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p actual %p", e, rsp.data);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("zobrist_transposition_table_tb failed");
      $finish;
    end
  end

  initial begin
    dir_row_t rows[$];
    dir_row_t row;
    ztt_pkg::req_t r;
    logic [63:0] ones;
    ones = '1;
    rst_ni = 1'b0;
    req.valid = 1'b0;
    req.data = '0;
    quiet = 1'b0;
    mismatches = 0;
    cycles = 0;
    for (int i = 0; i < ztt_pkg::SlotCount; i++) slot_used[i] = 1'b0;
    for (int i = 0; i < PoolSize; i++) begin
      pool_a[i] = rand_mask();
      pool_b[i] = rand_mask();
    end
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Every key is written before anything is hashed
    for (int i = 0; i < ztt_pkg::KeyCount; i++) begin
      r = '0;
      r.op = ztt_pkg::OpLoadKey;
      r.key_slot = 7'(i);
      r.key_word = $urandom;
      send_beat(r, 1'b1, '0);
    end

    // Directed rows; typed expectations only for all-zero answers
    row.typed = 1'b0;
    row.exp = '0;
    row.req = '0;
    row.req.op = ztt_pkg::OpLookup;                           rows.push_back(row);
    row.req.op = ztt_pkg::OpInsert; row.req.search_depth = 6'd5;
    row.req.payload_in = 32'hdeadbeef;                        rows.push_back(row);
    row.req.op = ztt_pkg::OpLookup;                           rows.push_back(row);
    row.req.op = ztt_pkg::OpInsert; row.req.search_depth = 6'd5;
    rows.push_back(row);
    row.req.search_depth = 6'd6;                              rows.push_back(row);
    row.req = '1;
    row.req.op = ztt_pkg::OpInsert;                           rows.push_back(row);
    row.req.op = ztt_pkg::OpLookup;                           rows.push_back(row);
    row.req.op = ztt_pkg::OpInsert;                           rows.push_back(row);
    row.typed = 1'b1;
    row.req.op = ztt_pkg::OpAge;                              rows.push_back(row);
    row.req.op = ztt_pkg::OpAge;                              rows.push_back(row);
    row.req.op = OpSpareLo;                                   rows.push_back(row);
    row.req.op = 3'd6;                                        rows.push_back(row);
    row.req.op = OpSpareHi;                                   rows.push_back(row);
    row.typed = 1'b0;
    row.req = '0;
    row.req.op = ztt_pkg::OpInsert; row.req.search_depth = 6'd0;
    rows.push_back(row);
    row.req.op = ztt_pkg::OpLookup; row.req.first_side_bits = ones;
    row.req.second_side_bits = ones;                          rows.push_back(row);
    row.typed = 1'b1;
    row.req.op = ztt_pkg::OpClear;                            rows.push_back(row);
    row.typed = 1'b0;
    row.req.op = ztt_pkg::OpLookup;                           rows.push_back(row);
    row.req.op = ztt_pkg::OpLookup; row.req.first_side_bits = '0;
    rows.push_back(row);
    row.typed = 1'b1;
    row.req = '0;
    row.req.op = ztt_pkg::OpLoadKey; row.req.key_slot = 7'h7f;
    row.req.key_word = '1;                                    rows.push_back(row);
    row.req.key_slot = 7'd0; row.req.key_word = '0;           rows.push_back(row);
    foreach (rows[i]) send_beat(rows[i].req, rows[i].typed, rows[i].exp);

    // Random, full-width keys: few slot collisions
    for (int i = 0; i < PhaseItems; i++) send_beat(rand_beat(1'b0));

    // Hold the sender until the block has answered everything
    park_sender();
    while (pending_rsp.size() != 0) @(posedge clk_i);

    // Narrow keys squeeze positions into 16 slots to force replacements
    for (int i = 0; i < ztt_pkg::KeyCount; i++) begin
      r = '0;
      r.op = ztt_pkg::OpLoadKey;
      r.key_slot = 7'(i);
      r.key_word = $urandom & 32'hf;
      send_beat(r);
    end
    for (int i = 0; i < PhaseItems; i++) begin
      if (i == PhaseItems - QuietItems) quiet = 1'b1;
      send_beat(rand_beat(1'b1));
    end
    park_sender();

    // Drain, then watch for stray beats
    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatches == 0 && pending_rsp.size() == 0) begin
      $display("zobrist_transposition_table_tb passed");
    end else begin
      $display("zobrist_transposition_table_tb failed");
    end
    $finish;
  end

endmodule
